// ===== design/gf2ch_pkg.sv =====
// package for the gf2 group compress and hash core
// field widths, operation codes, parameter defaults and shared types
// no dependencies
package gf2ch_pkg;

  // transaction field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 5;
  localparam int ROW_W   = 32;
  localparam int GRP_W   = 32;
  localparam int COMP_W  = 24;
  localparam int HASHO_W = 8;

  // parity fold granularity of the product stage
  localparam int CHUNK_W = 8;

  // parameter defaults
  localparam int GROUP_BITS_DEF = 32;
  localparam int ALPHA_DEF      = 8;
  localparam int HASH_BITS_DEF  = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_Z    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_HASH = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPRESS  = 2'd2;

  // matrix row write request
  typedef struct packed {
    logic             z_we;
    logic             h_we;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] row;
  } mat_wr_t;

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== design/gf2ch_if.sv =====
// valid/ready channel interfaces for the input and result transactions
// depends on gf2ch_pkg
interface gf2ch_in_if;
  import gf2ch_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] row_index;
  logic [ROW_W-1:0] row_bits;
  logic [GRP_W-1:0] group_bits;

  modport source(output valid, output operation, output row_index, output row_bits,
                 output group_bits, input ready);
  modport sink(input valid, input operation, input row_index, input row_bits,
               input group_bits, output ready);
endinterface

interface gf2ch_out_if;
  import gf2ch_pkg::*;
  logic               valid;
  logic               ready;
  logic [COMP_W-1:0]  compressed_bits;
  logic [HASHO_W-1:0] hash_bits;

  modport source(output valid, output compressed_bits, output hash_bits, input ready);
  modport sink(input valid, input compressed_bits, input hash_bits, output ready);
endinterface

// ===== design/gf2ch_mat_store.sv =====
// row storage for the z part of the compression matrix and the hash matrix
// only rows that reach a result bit are kept; depends on gf2ch_pkg
module gf2ch_mat_store #(
  parameter int GROUP_BITS = gf2ch_pkg::GROUP_BITS_DEF,
  parameter int ALPHA      = gf2ch_pkg::ALPHA_DEF,
  parameter int HASH_BITS  = gf2ch_pkg::HASH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gf2ch_pkg::mat_wr_t wr,
  output logic [ALPHA-1:0]  z_rows [gf2ch_pkg::imin(GROUP_BITS - ALPHA, gf2ch_pkg::COMP_W)],
  output logic [gf2ch_pkg::imin(GROUP_BITS, gf2ch_pkg::GRP_W)-1:0]
                            h_rows [gf2ch_pkg::imin(HASH_BITS, gf2ch_pkg::HASHO_W)]
);
  import gf2ch_pkg::*;

  localparam int NZ = imin(GROUP_BITS - ALPHA, COMP_W);
  localparam int NH = imin(HASH_BITS, HASHO_W);
  localparam int GW = imin(GROUP_BITS, GRP_W);

  logic [ALPHA-1:0] z_rows_r [NZ];
  logic [GW-1:0]    h_rows_r [NH];
  logic [63:0]      row64;

  assign row64 = {32'b0, wr.row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NZ; i++) z_rows_r[i] <= '0;
      for (int r = 0; r < NH; r++) h_rows_r[r] <= '0;
    end else begin
      for (int i = 0; i < NZ; i++) begin
        if (wr.z_we && (32'(wr.idx) == i)) z_rows_r[i] <= row64[ALPHA-1:0];
      end
      for (int r = 0; r < NH; r++) begin
        if (wr.h_we && (32'(wr.idx) == r)) h_rows_r[r] <= row64[GW-1:0];
      end
    end
  end

  assign z_rows = z_rows_r;
  assign h_rows = h_rows_r;

endmodule

// ===== design/gf2ch_fold.sv =====
// product stage: and of each matrix row with the group, folded to chunk parities
// registered with its own valid; depends on gf2ch_pkg
module gf2ch_fold #(
  parameter int GROUP_BITS = gf2ch_pkg::GROUP_BITS_DEF,
  parameter int ALPHA      = gf2ch_pkg::ALPHA_DEF,
  parameter int HASH_BITS  = gf2ch_pkg::HASH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_v,
  input  logic [gf2ch_pkg::GRP_W-1:0]   grp,
  input  logic [ALPHA-1:0]              z_rows [gf2ch_pkg::imin(GROUP_BITS - ALPHA,
                                                                 gf2ch_pkg::COMP_W)],
  input  logic [gf2ch_pkg::imin(GROUP_BITS, gf2ch_pkg::GRP_W)-1:0]
                                        h_rows [gf2ch_pkg::imin(HASH_BITS, gf2ch_pkg::HASHO_W)],
  input  logic                          nxt_ready,
  output logic                          ready,
  output logic                          s2_v,
  output logic [gf2ch_pkg::imin(GROUP_BITS - ALPHA, gf2ch_pkg::COMP_W)-1:0] s2_lo,
  output logic [(ALPHA + gf2ch_pkg::CHUNK_W - 1) / gf2ch_pkg::CHUNK_W - 1:0]
                                        s2_zpar [gf2ch_pkg::imin(GROUP_BITS - ALPHA,
                                                                 gf2ch_pkg::COMP_W)],
  output logic [(gf2ch_pkg::imin(GROUP_BITS, gf2ch_pkg::GRP_W) + gf2ch_pkg::CHUNK_W - 1)
                / gf2ch_pkg::CHUNK_W - 1:0]
                                        s2_hpar [gf2ch_pkg::imin(HASH_BITS, gf2ch_pkg::HASHO_W)]
);
  import gf2ch_pkg::*;

  localparam int NZ    = imin(GROUP_BITS - ALPHA, COMP_W);
  localparam int NH    = imin(HASH_BITS, HASHO_W);
  localparam int GW    = imin(GROUP_BITS, GRP_W);
  localparam int CROWS = GROUP_BITS - ALPHA;
  localparam int ZCH   = (ALPHA + CHUNK_W - 1) / CHUNK_W;
  localparam int HCH   = (GW + CHUNK_W - 1) / CHUNK_W;

  logic [63:0]      g64;
  logic [ALPHA-1:0] tail;
  logic [ZCH-1:0]   zpar_nxt [NZ];
  logic [HCH-1:0]   hpar_nxt [NH];

  logic             s2_v_r;
  logic [NZ-1:0]    s2_lo_r;
  logic [ZCH-1:0]   s2_zpar_r [NZ];
  logic [HCH-1:0]   s2_hpar_r [NH];

  // group zero extended to 64 bits so that slices past GRP_W read zero
  assign g64  = {32'b0, grp};
  assign tail = g64[CROWS +: ALPHA];

  always_comb begin
    logic [ZCH*CHUNK_W-1:0] zprod;
    logic [HCH*CHUNK_W-1:0] hprod;
    for (int i = 0; i < NZ; i++) begin
      zprod = (ZCH*CHUNK_W)'(z_rows[i] & tail);
      for (int c = 0; c < ZCH; c++) zpar_nxt[i][c] = ^zprod[c*CHUNK_W +: CHUNK_W];
    end
    for (int r = 0; r < NH; r++) begin
      hprod = (HCH*CHUNK_W)'(h_rows[r] & g64[GW-1:0]);
      for (int c = 0; c < HCH; c++) hpar_nxt[r][c] = ^hprod[c*CHUNK_W +: CHUNK_W];
    end
  end

  assign ready = !s2_v_r || nxt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (ready) begin
      s2_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_v) begin
      s2_lo_r   <= g64[NZ-1:0];
      s2_zpar_r <= zpar_nxt;
      s2_hpar_r <= hpar_nxt;
    end
  end

  assign s2_v    = s2_v_r;
  assign s2_lo   = s2_lo_r;
  assign s2_zpar = s2_zpar_r;
  assign s2_hpar = s2_hpar_r;

endmodule

// ===== design/gf2ch_finish.sv =====
// final stage: chunk parities reduced to result bits, identity part added
// holds the result register of the output channel; depends on gf2ch_pkg
module gf2ch_finish #(
  parameter int GROUP_BITS = gf2ch_pkg::GROUP_BITS_DEF,
  parameter int ALPHA      = gf2ch_pkg::ALPHA_DEF,
  parameter int HASH_BITS  = gf2ch_pkg::HASH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            s2_v,
  input  logic [gf2ch_pkg::imin(GROUP_BITS - ALPHA, gf2ch_pkg::COMP_W)-1:0] s2_lo,
  input  logic [(ALPHA + gf2ch_pkg::CHUNK_W - 1) / gf2ch_pkg::CHUNK_W - 1:0]
                                          s2_zpar [gf2ch_pkg::imin(GROUP_BITS - ALPHA,
                                                                   gf2ch_pkg::COMP_W)],
  input  logic [(gf2ch_pkg::imin(GROUP_BITS, gf2ch_pkg::GRP_W) + gf2ch_pkg::CHUNK_W - 1)
                / gf2ch_pkg::CHUNK_W - 1:0]
                                          s2_hpar [gf2ch_pkg::imin(HASH_BITS, gf2ch_pkg::HASHO_W)],
  input  logic                            out_ready,
  output logic                            ready,
  output logic                            out_v,
  output logic [gf2ch_pkg::COMP_W-1:0]    out_comp,
  output logic [gf2ch_pkg::HASHO_W-1:0]   out_hash
);
  import gf2ch_pkg::*;

  localparam int NZ = imin(GROUP_BITS - ALPHA, COMP_W);
  localparam int NH = imin(HASH_BITS, HASHO_W);

  logic [NZ-1:0]      zred;
  logic [NH-1:0]      hred;
  logic               out_v_r;
  logic [COMP_W-1:0]  out_comp_r;
  logic [HASHO_W-1:0] out_hash_r;

  always_comb begin
    for (int i = 0; i < NZ; i++) zred[i] = ^s2_zpar[i];
    for (int r = 0; r < NH; r++) hred[r] = ^s2_hpar[r];
  end

  assign ready = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ready) begin
      out_v_r <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && s2_v) begin
      out_comp_r <= COMP_W'(s2_lo ^ zred);
      out_hash_r <= HASHO_W'(hred);
    end
  end

  assign out_v    = out_v_r;
  assign out_comp = out_comp_r;
  assign out_hash = out_hash_r;

endmodule

// ===== design/gf2ch_core_top.sv =====
// an accepted compress transaction passes the stage 1 register, the stage 2 parity register
// and the stage 3 result register, where it waits until out ready takes it
// one transaction per cycle unless out ready stalls, set by the three register stages each
// taking one per cycle; loads take a slot in the first stage and give no result
// reset: synchronous active-low rst_n empties all stages and clears both matrices to zero
// depends on gf2ch_pkg, gf2ch_if, gf2ch_mat_store, gf2ch_fold, gf2ch_finish
module gf2_group_compress_and_hash_core #(
  parameter int GROUP_BITS = gf2ch_pkg::GROUP_BITS_DEF,
  parameter int ALPHA      = gf2ch_pkg::ALPHA_DEF,
  parameter int HASH_BITS  = gf2ch_pkg::HASH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gf2ch_in_if.sink    in_chan,
  gf2ch_out_if.source out_chan
);
  import gf2ch_pkg::*;

  localparam int NZ  = imin(GROUP_BITS - ALPHA, COMP_W);
  localparam int NH  = imin(HASH_BITS, HASHO_W);
  localparam int GW  = imin(GROUP_BITS, GRP_W);
  localparam int ZCH = (ALPHA + CHUNK_W - 1) / CHUNK_W;
  localparam int HCH = (GW + CHUNK_W - 1) / CHUNK_W;

  // stage 1: accepted transaction, decoded as it leaves
  logic             s1_v_r;
  logic [OP_W-1:0]  s1_op_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [GRP_W-1:0] s1_grp_r;
  logic             s1_ready;
  logic             s1_adv;
  logic             s2_in_v;

  // matrix storage
  mat_wr_t          mat_wr;
  logic [ALPHA-1:0] z_rows [NZ];
  logic [GW-1:0]    h_rows [NH];

  // stage 2: chunk parities
  logic             s2_ready;
  logic             s2_v;
  logic [NZ-1:0]    s2_lo;
  logic [ZCH-1:0]   s2_zpar [NZ];
  logic [HCH-1:0]   s2_hpar [NH];

  // stage 3: result register
  logic             s3_ready;

  // stage 1 frees itself whenever stage 2 can take its contents
  assign s1_ready      = !s1_v_r || s2_ready;
  assign in_chan.ready = s1_ready;
  assign s1_adv        = s1_v_r && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_chan.valid) begin
      s1_op_r  <= in_chan.operation;
      s1_idx_r <= in_chan.row_index;
      s1_row_r <= in_chan.row_bits;
      s1_grp_r <= in_chan.group_bits;
    end
  end

  // a load writes its row as it leaves stage 1, so any compress behind it
  // reads the new row when it leaves stage 1 in a later cycle
  always_comb begin
    mat_wr.z_we = s1_adv && (s1_op_r == OP_LOAD_Z);
    mat_wr.h_we = s1_adv && (s1_op_r == OP_LOAD_HASH);
    mat_wr.idx  = s1_idx_r;
    mat_wr.row  = s1_row_r;
  end

  // only compress transactions go on; loads and the unused code drop here
  assign s2_in_v = s1_v_r && (s1_op_r == OP_COMPRESS);

  gf2ch_mat_store #(
    .GROUP_BITS(GROUP_BITS),
    .ALPHA     (ALPHA),
    .HASH_BITS (HASH_BITS)
  ) u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mat_wr),
    .z_rows(z_rows),
    .h_rows(h_rows)
  );

  gf2ch_fold #(
    .GROUP_BITS(GROUP_BITS),
    .ALPHA     (ALPHA),
    .HASH_BITS (HASH_BITS)
  ) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (s2_in_v),
    .grp      (s1_grp_r),
    .z_rows   (z_rows),
    .h_rows   (h_rows),
    .nxt_ready(s3_ready),
    .ready    (s2_ready),
    .s2_v     (s2_v),
    .s2_lo    (s2_lo),
    .s2_zpar  (s2_zpar),
    .s2_hpar  (s2_hpar)
  );

  gf2ch_finish #(
    .GROUP_BITS(GROUP_BITS),
    .ALPHA     (ALPHA),
    .HASH_BITS (HASH_BITS)
  ) u_finish (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_v     (s2_v),
    .s2_lo    (s2_lo),
    .s2_zpar  (s2_zpar),
    .s2_hpar  (s2_hpar),
    .out_ready(out_chan.ready),
    .ready    (s3_ready),
    .out_v    (out_chan.valid),
    .out_comp (out_chan.compressed_bits),
    .out_hash (out_chan.hash_bits)
  );

  // a row write and a compress never leave stage 1 together
  a_wr_vs_compress: assert property (@(posedge clk) disable iff (!rst_n)
    !((mat_wr.z_we || mat_wr.h_we) && s2_in_v))
    else $error("matrix write with compress in flight");

  // a compress that leaves stage 1 lands in stage 2
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_in_v && s2_ready) |=> s2_v)
    else $error("compress transaction lost between stage 1 and 2");

  // a stalled stage 2 keeps its transaction
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v && !s3_ready) |=> s2_v)
    else $error("stage 2 transaction dropped under stall");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

endmodule

// ===== verif/gf2ch_tb_pkg.sv =====
// scoreboard for the gf2 group compress and hash core testbench
// holds its own copy of both matrices and the queue of expected digests
// depends on gf2ch_pkg
package gf2ch_tb_pkg;
  import gf2ch_pkg::*;

  localparam int Z_ROWS = GROUP_BITS_DEF - ALPHA_DEF;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [COMP_W-1:0]  comp;
    logic [HASHO_W-1:0] hash;
  } digest_t;

  class gf2ch_scoreboard;
    logic [ALPHA_DEF-1:0]      z_rows    [Z_ROWS];
    logic [GROUP_BITS_DEF-1:0] hash_rows [HASH_BITS_DEF];
    digest_t                   digests_due[$];
    int                        mismatches;
    int                        checked;

    function new();
      foreach (z_rows[i]) z_rows[i] = '0;
      foreach (hash_rows[i]) hash_rows[i] = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    // [I | Z] product plus the hash product, both over GF(2)
    function digest_t compress_group(logic [GRP_W-1:0] grp);
      digest_t             d;
      logic [ALPHA_DEF-1:0] tail;
      d    = '0;
      tail = grp[GROUP_BITS_DEF-1 -: ALPHA_DEF];
      for (int i = 0; i < Z_ROWS; i++) d.comp[i] = grp[i] ^ (^(z_rows[i] & tail));
      for (int r = 0; r < HASH_BITS_DEF; r++) d.hash[r] = ^(hash_rows[r] & grp);
      return d;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                             logic [ROW_W-1:0] row, logic [GRP_W-1:0] grp);
      case (op)
        OP_LOAD_Z: begin
          if (idx < Z_ROWS) z_rows[idx] = row[ALPHA_DEF-1:0];
        end
        OP_LOAD_HASH: begin
          if (idx < HASH_BITS_DEF) hash_rows[idx] = row[GROUP_BITS_DEF-1:0];
        end
        OP_COMPRESS: begin
          digests_due.push_back(compress_group(grp));
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [COMP_W-1:0] comp, logic [HASHO_W-1:0] hash);
      digest_t want;
      if (digests_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual comp %h hash %h",
                 $time, comp, hash);
        return;
      end
      want = digests_due.pop_front();
      checked++;
      if (comp !== want.comp) begin
        mismatches++;
        $display("%0t: compressed_bits mismatch, expected %h actual %h",
                 $time, want.comp, comp);
      end
      if (hash !== want.hash) begin
        mismatches++;
        $display("%0t: hash_bits mismatch, expected %h actual %h", $time, want.hash, hash);
      end
    endfunction

    function int outstanding();
      return digests_due.size();
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// top-level testbench for gf2_group_compress_and_hash_core
// drives load, compress and reserved transactions with random gaps and stalls,
// checks every result against the scoreboard; depends on gf2ch_pkg, gf2ch_if, gf2ch_tb_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gf2ch_pkg::*;
  import gf2ch_tb_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STALL_LIMIT  = 600;
  localparam int DRAIN_CYCLES = 8;

  // how a side spaces its transactions
  typedef enum int {PACE_BACK_TO_BACK, PACE_STEADY_GAPS, PACE_OCCASIONAL} pace_t;

  logic clk = 1'b0;
  logic rst_n;

  gf2ch_in_if  in_chan();
  gf2ch_out_if out_chan();

  gf2ch_scoreboard sb;
  pace_t           in_pace;
  pace_t           out_pace;
  int              sent_items;
  int              load_items;
  int              idle_run;

  gf2_group_compress_and_hash_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #HALF_PERIOD clk = ~clk;

  // cycles to wait before the next transaction on one side
  function automatic int draw_wait(pace_t pace);
    case (pace)
      PACE_BACK_TO_BACK: return 0;
      PACE_STEADY_GAPS:  return $urandom_range(0, 17);
      default:           return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  // groups biased toward the edges: all zero, all one, single bits, tail only
  function automatic logic [GRP_W-1:0] draw_group();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'd1 << $urandom_range(0, GRP_W-1);
      3:       return {8'($urandom_range(0, 255)), 24'h0};
      default: return $urandom;
    endcase
  endfunction

  // one transaction on the input channel; valid stays high across back-to-back transactions
  task automatic push_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [ROW_W-1:0] row, logic [GRP_W-1:0] grp);
    int gap;
    gap = draw_wait(in_pace);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.operation  <= op;
    in_chan.row_index  <= idx;
    in_chan.row_bits   <= row;
    in_chan.group_bits <= grp;
    in_chan.valid      <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    // accepted at this edge: mirror it in the scoreboard
    sb.note_input(op, idx, row, grp);
    sent_items++;
    if (op == OP_LOAD_Z || op == OP_LOAD_HASH) load_items++;
  endtask

  // fresh random contents for every row of both matrices
  task automatic reload_matrices();
    for (int i = 0; i < Z_ROWS; i++) push_item(OP_LOAD_Z, IDX_W'(i), $urandom, $urandom);
    for (int i = 0; i < HASH_BITS_DEF; i++) begin
      push_item(OP_LOAD_HASH, IDX_W'(i), $urandom, $urandom);
    end
  endtask

  task automatic run_directed();
    // zero matrices after reset: compression is the identity, hash is zero
    push_item(OP_COMPRESS, '0, '0, '1);
    push_item(OP_COMPRESS, '1, '1, '0);
    // excess row bits dropped, first and last rows
    push_item(OP_LOAD_Z, 5'd0, '1, '0);
    push_item(OP_LOAD_Z, 5'd23, 32'hFFFF_FFA5, '1);
    // out-of-range z rows are ignored
    push_item(OP_LOAD_Z, 5'd24, '1, '1);
    push_item(OP_LOAD_Z, 5'd31, '1, '0);
    push_item(OP_LOAD_HASH, 5'd0, '1, '0);
    push_item(OP_LOAD_HASH, 5'd7, 32'h8000_0001, '1);
    // out-of-range hash rows are ignored
    push_item(OP_LOAD_HASH, 5'd8, '1, '1);
    push_item(OP_LOAD_HASH, 5'd31, '1, '0);
    // reserved opcode changes nothing and gives no result
    push_item(OP_RESERVED, '1, '1, '1);
    push_item(OP_RESERVED, '0, '0, '0);
    push_item(OP_COMPRESS, '0, '0, 32'hFF00_0000);
    push_item(OP_COMPRESS, '0, '0, '1);
    push_item(OP_COMPRESS, '0, '0, 32'h00FF_FFFF);
    // row fields ignored on a compress transaction
    push_item(OP_COMPRESS, '1, '1, 32'h8000_0001);
    push_item(OP_LOAD_Z, 5'd5, 32'h0000_0081, '1);
    push_item(OP_LOAD_HASH, 5'd3, 32'hAAAA_5555, '0);
    push_item(OP_COMPRESS, '1, '0, 32'h0100_0020);
    push_item(OP_COMPRESS, '0, '1, 32'h5555_AAAA);
    push_item(OP_COMPRESS, '0, '0, '0);
  endtask

  task automatic run_random();
    int kind;
    int count;
    count = 0;
    while (count < RANDOM_ITEMS) begin
      // change pace on both sides now and then, including stretches with no gaps
      if (count % 150 == 0) begin
        in_pace  = pace_t'($urandom_range(0, 2));
        out_pace = pace_t'($urandom_range(0, 2));
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        push_item(OP_COMPRESS, IDX_W'($urandom), $urandom, draw_group());
      end else if (kind < 70) begin
        push_item(OP_LOAD_Z, IDX_W'($urandom_range(0, Z_ROWS-1)), $urandom, $urandom);
      end else if (kind < 82) begin
        push_item(OP_LOAD_HASH, IDX_W'($urandom_range(0, HASH_BITS_DEF-1)), $urandom,
                  $urandom);
      end else if (kind < 86) begin
        push_item(OP_LOAD_Z, IDX_W'($urandom_range(Z_ROWS, 31)), $urandom, $urandom);
      end else if (kind < 89) begin
        push_item(OP_LOAD_HASH, IDX_W'($urandom_range(HASH_BITS_DEF, 31)), $urandom,
                  $urandom);
      end else if (kind < 93) begin
        push_item(OP_RESERVED, IDX_W'($urandom), $urandom, $urandom);
      end else if (kind < 99) begin
        // fully random fields, opcode included
        push_item(OP_W'($urandom), IDX_W'($urandom), $urandom, $urandom);
      end else begin
        reload_matrices();
        count += Z_ROWS + HASH_BITS_DEF - 1;
      end
      count++;
    end
  endtask

  // result side: random stalls before each transaction, then check it
  initial begin
    out_chan.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      int stall;
      stall = draw_wait(out_pace);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      sb.check_result(out_chan.compressed_bits, out_chan.hash_bits);
    end
  end

  // watchdog: too long with no transaction on either channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results still due",
               $time, idle_run, sb.outstanding());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    sb         = new();
    sent_items = 0;
    load_items = 0;
    idle_run   = 0;
    in_pace    = PACE_OCCASIONAL;
    out_pace   = PACE_STEADY_GAPS;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.operation   <= OP_LOAD_Z;
    in_chan.row_index   <= '0;
    in_chan.row_bits    <= '0;
    in_chan.group_bits  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    in_chan.valid <= 1'b0;

    // let the pipeline drain, then a few more cycles to catch stray results
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d transactions sent (%0d loads), %0d results checked, %0d mismatches",
             sent_items, load_items, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
